// ===== rtl/core/sapd_pkg.sv =====
package sapd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 40;
  localparam int ACC_W    = 44;
  localparam int IDX_W    = 3;
  localparam int TABLE_N  = 8;

  localparam int SWELL_DEPTH_DEF    = 4096;
  localparam int DIFFUSER_DEPTH_DEF = 2048;
  localparam int TAP_COUNT_DEF      = 4;
  localparam int STAGE_COUNT_DEF    = 4;

  localparam int ROW_TAP   = 0;
  localparam int ROW_STAGE = 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0]   COEF_LIMIT = 16'sd24576;
  localparam logic signed [COEF_W-1:0]   GAIN_DIRECT = 16'sd3932;
  localparam logic signed [COEF_W-1:0]   GAIN_DRY    = 16'sd20316;
  localparam logic signed [COEF_W-1:0]   GAIN_RESET  = 16'sd15401;
  localparam logic signed [ACC_W-1:0]    RND_HALF    = 44'sd16384;

  typedef logic [15:0] len_t;

  // rows: left taps, right taps, left stages, right stages
  localparam len_t DELAY_TABLE [4][TABLE_N] = '{
    '{16'd379, 16'd907,  16'd1637, 16'd2677, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd439, 16'd1013, 16'd1789, 16'd2887, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd281, 16'd389,  16'd547,  16'd773,  16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd307, 16'd431,  16'd601,  16'd839,  16'd0, 16'd0, 16'd0, 16'd0}
  };

  localparam logic signed [COEF_W-1:0] TAP_GAIN [TABLE_N] = '{
    16'sd3277, 16'sd5243, 16'sd8192, 16'sd12124, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAP,
    ST_SROUND,
    ST_STAGE,
    ST_FMUL,
    ST_FRES,
    ST_DONE
  } sapd_state_e;

  typedef struct packed {
    logic             load;
    logic             tap_rd;
    logic [IDX_W-1:0] tap_rd_idx;
    logic             tap_mul;
    logic [IDX_W-1:0] tap_mul_idx;
    logic             tap_acc;
    logic             sround;
    logic             st_rd;
    logic             st_y;
    logic             st_mul2;
    logic             st_wr;
    logic [IDX_W-1:0] stage;
    logic             fin_mul;
    logic             fin_res;
  } sapd_op_t;

  typedef struct packed {
    logic in_ready;
    logic out_load;
    logic clearing;
  } sapd_stat_t;

  function automatic logic signed [SAMPLE_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + RND_HALF) >>> 15;
    if (t > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end else if (t < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return t[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_q15(input logic signed [SAMPLE_W-1:0] s);
    return {{(ACC_W-SAMPLE_W-15){s[SAMPLE_W-1]}}, s, 15'b0};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
    return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp_coef(input logic signed [COEF_W-1:0] g);
    if (g > COEF_LIMIT) begin
      return COEF_LIMIT;
    end else if (g < -COEF_LIMIT) begin
      return -COEF_LIMIT;
    end
    return g;
  endfunction

  function automatic len_t tap_len(input len_t raw, input int depth);
    if (raw < 16'd1) begin
      return 16'd1;
    end else if (int'(raw) > depth - 1) begin
      return len_t'(depth - 1);
    end
    return raw;
  endfunction

  function automatic len_t stage_len(input len_t raw, input int depth);
    if (int'(raw) > depth) begin
      return len_t'(depth);
    end
    return raw;
  endfunction

endpackage

// ===== rtl/core/sapd_ctrl.sv =====
module sapd_ctrl #(
  parameter int SWELL_DEPTH    = sapd_pkg::SWELL_DEPTH_DEF,
  parameter int DIFFUSER_DEPTH = sapd_pkg::DIFFUSER_DEPTH_DEF,
  parameter int TAP_COUNT      = sapd_pkg::TAP_COUNT_DEF,
  parameter int STAGE_COUNT    = sapd_pkg::STAGE_COUNT_DEF,
  localparam int SW    = $clog2(SWELL_DEPTH),
  localparam int CLR_N = (SWELL_DEPTH > STAGE_COUNT * DIFFUSER_DEPTH) ?
                         SWELL_DEPTH : STAGE_COUNT * DIFFUSER_DEPTH,
  localparam int CW    = $clog2(CLR_N)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  output sapd_pkg::sapd_op_t op_o,
  output sapd_pkg::sapd_stat_t stat_o,
  output logic [SW-1:0]      wptr_o,
  output logic               clr_en_o,
  output logic [CW-1:0]      clr_addr_o
);

  sapd_pkg::sapd_state_e state_q, state_d;
  logic [CW-1:0]               clr_q, clr_d;
  logic [3:0]                  k_q, k_d;
  logic [sapd_pkg::IDX_W-1:0]  j_q, j_d;
  logic [1:0]                  sub_q, sub_d;
  logic [SW-1:0]               wptr_q, wptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sapd_pkg::ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      j_q     <= '0;
      sub_q   <= '0;
      wptr_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      j_q     <= j_d;
      sub_q   <= sub_d;
      wptr_q  <= wptr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    j_d     = j_q;
    sub_d   = sub_q;
    wptr_d  = wptr_q;
    case (state_q)
      sapd_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CW'(CLR_N - 1)) begin
          state_d = sapd_pkg::ST_IDLE;
        end
      end
      sapd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sapd_pkg::ST_TAP;
          k_d     = '0;
        end
      end
      sapd_pkg::ST_TAP: begin
        k_d = k_q + 1'b1;
        if (k_q == 4'(TAP_COUNT + 1)) begin
          state_d = sapd_pkg::ST_SROUND;
        end
      end
      sapd_pkg::ST_SROUND: begin
        state_d = sapd_pkg::ST_STAGE;
        j_d     = '0;
        sub_d   = '0;
      end
      sapd_pkg::ST_STAGE: begin
        sub_d = sub_q + 1'b1;
        if (sub_q == 2'd3) begin
          j_d = j_q + 1'b1;
          if (j_q == sapd_pkg::IDX_W'(STAGE_COUNT - 1)) begin
            state_d = sapd_pkg::ST_FMUL;
          end
        end
      end
      sapd_pkg::ST_FMUL: state_d = sapd_pkg::ST_FRES;
      sapd_pkg::ST_FRES: state_d = sapd_pkg::ST_DONE;
      sapd_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = sapd_pkg::ST_IDLE;
          // advance the shared swell write pointer once per item
          wptr_d  = (wptr_q == SW'(SWELL_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
        end
      end
      default: state_d = sapd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    op_o        = '0;
    stat_o      = '0;
    clr_en_o    = 1'b0;
    case (state_q)
      sapd_pkg::ST_CLEAR: begin
        clr_en_o        = 1'b1;
        stat_o.clearing = 1'b1;
      end
      sapd_pkg::ST_IDLE: begin
        stat_o.in_ready = 1'b1;
        op_o.load       = in_valid_i;
      end
      sapd_pkg::ST_TAP: begin
        op_o.tap_rd      = (k_q < 4'(TAP_COUNT));
        op_o.tap_rd_idx  = k_q[sapd_pkg::IDX_W-1:0];
        op_o.tap_mul     = (k_q >= 4'd1) && (k_q <= 4'(TAP_COUNT));
        op_o.tap_mul_idx = sapd_pkg::IDX_W'(k_q - 4'd1);
        op_o.tap_acc     = (k_q >= 4'd2);
      end
      sapd_pkg::ST_SROUND: op_o.sround = 1'b1;
      sapd_pkg::ST_STAGE: begin
        op_o.stage   = j_q;
        op_o.st_rd   = (sub_q == 2'd0);
        op_o.st_y    = (sub_q == 2'd1);
        op_o.st_mul2 = (sub_q == 2'd2);
        op_o.st_wr   = (sub_q == 2'd3);
      end
      sapd_pkg::ST_FMUL: op_o.fin_mul = 1'b1;
      sapd_pkg::ST_FRES: op_o.fin_res = 1'b1;
      sapd_pkg::ST_DONE: stat_o.out_load = out_free_i;
      default: ;
    endcase
  end

  assign wptr_o     = wptr_q;
  assign clr_addr_o = clr_q;

endmodule

// ===== rtl/core/sapd_lane.sv =====
module sapd_lane #(
  parameter int CH             = 0,
  parameter int SWELL_DEPTH    = sapd_pkg::SWELL_DEPTH_DEF,
  parameter int DIFFUSER_DEPTH = sapd_pkg::DIFFUSER_DEPTH_DEF,
  parameter int STAGE_COUNT    = sapd_pkg::STAGE_COUNT_DEF,
  localparam int SW    = $clog2(SWELL_DEPTH),
  localparam int DW    = $clog2(DIFFUSER_DEPTH),
  localparam int DN    = STAGE_COUNT * DIFFUSER_DEPTH,
  localparam int AW    = (DN > 1) ? $clog2(DN) : 1,
  localparam int CLR_N = (SWELL_DEPTH > DN) ? SWELL_DEPTH : DN,
  localparam int CW    = $clog2(CLR_N)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sapd_pkg::sapd_op_t                     op_i,
  input  logic [SW-1:0]                          wptr_i,
  input  logic                                   clr_en_i,
  input  logic [CW-1:0]                          clr_addr_i,
  input  logic signed [sapd_pkg::COEF_W-1:0]     gain_i,
  input  logic signed [sapd_pkg::SAMPLE_W-1:0]   x_i,
  output logic signed [sapd_pkg::SAMPLE_W-1:0]   res_o
);

  logic [sapd_pkg::SAMPLE_W-1:0] swell_mem [SWELL_DEPTH];
  logic [sapd_pkg::SAMPLE_W-1:0] diff_mem [DN];
  logic signed [sapd_pkg::SAMPLE_W-1:0] sw_rdata_q, df_rdata_q;

  logic signed [sapd_pkg::SAMPLE_W-1:0] x_q, v_q, y_q, res_q;
  logic signed [sapd_pkg::ACC_W-1:0]    acc_q;
  logic signed [sapd_pkg::PROD_W-1:0]   prod_q, load_prod;
  logic [DW-1:0]                        ptr_q [STAGE_COUNT];

  sapd_pkg::len_t  t_len, s_len;
  logic [SW:0]     w_ext, r_ext;
  logic [SW-1:0]   sw_raddr;
  logic [DW-1:0]   cur_ptr, p_eff;
  logic [DW:0]     p_inc;
  logic [DW-1:0]   p_nxt;
  logic [AW-1:0]   df_addr;
  logic signed [sapd_pkg::SAMPLE_W-1:0] w_val;

  // tap read address: write pointer minus tap length, wrapped
  always_comb begin
    t_len = sapd_pkg::tap_len(sapd_pkg::DELAY_TABLE[sapd_pkg::ROW_TAP + CH][op_i.tap_rd_idx],
                              SWELL_DEPTH);
    w_ext = {1'b0, wptr_i};
    if (w_ext >= t_len[SW:0]) begin
      r_ext = w_ext - t_len[SW:0];
    end else begin
      r_ext = w_ext + (SW+1)'(SWELL_DEPTH) - t_len[SW:0];
    end
    sw_raddr = r_ext[SW-1:0];
  end

  always_comb begin
    s_len = sapd_pkg::stage_len(
              sapd_pkg::DELAY_TABLE[sapd_pkg::ROW_STAGE + CH][op_i.stage], DIFFUSER_DEPTH);
    cur_ptr = '0;
    for (int j = 0; j < STAGE_COUNT; j++) begin
      if (op_i.stage == sapd_pkg::IDX_W'(j)) begin
        cur_ptr = ptr_q[j];
      end
    end
    p_eff   = ({1'b0, cur_ptr} >= s_len[DW:0]) ? '0 : cur_ptr;
    p_inc   = {1'b0, p_eff} + 1'b1;
    p_nxt   = (p_inc >= s_len[DW:0]) ? '0 : p_inc[DW-1:0];
    df_addr = AW'(int'(op_i.stage) * DIFFUSER_DEPTH + int'(p_eff));
    w_val   = sapd_pkg::rnd_sat(sapd_pkg::ext_q15(v_q) + sapd_pkg::ext_prod(prod_q));
    load_prod = sapd_pkg::GAIN_DIRECT * x_i;
  end

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      if ({1'b0, clr_addr_i} < (CW+1)'(SWELL_DEPTH)) begin
        swell_mem[clr_addr_i[SW-1:0]] <= '0;
      end
    end else if (op_i.load) begin
      swell_mem[wptr_i] <= x_i;
    end
    sw_rdata_q <= swell_mem[sw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      if ({1'b0, clr_addr_i} < (CW+1)'(DN)) begin
        diff_mem[clr_addr_i[AW-1:0]] <= '0;
      end
    end else if (op_i.st_wr && (s_len != '0)) begin
      diff_mem[df_addr] <= w_val;
    end
    df_rdata_q <= diff_mem[df_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < STAGE_COUNT; j++) begin
        ptr_q[j] <= '0;
      end
    end else if (op_i.st_wr && (s_len != '0)) begin
      for (int j = 0; j < STAGE_COUNT; j++) begin
        if (op_i.stage == sapd_pkg::IDX_W'(j)) begin
          ptr_q[j] <= p_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.load) begin
      x_q   <= x_i;
      acc_q <= sapd_pkg::ext_prod(load_prod);
    end
    if (op_i.tap_mul) begin
      prod_q <= sapd_pkg::TAP_GAIN[op_i.tap_mul_idx] * sw_rdata_q;
    end
    if (op_i.tap_acc) begin
      acc_q <= acc_q + sapd_pkg::ext_prod(prod_q);
    end
    if (op_i.sround) begin
      v_q <= sapd_pkg::rnd_sat(acc_q);
    end
    if (op_i.st_rd) begin
      prod_q <= gain_i * v_q;
    end
    if (op_i.st_y) begin
      y_q <= sapd_pkg::rnd_sat(sapd_pkg::ext_q15(df_rdata_q) - sapd_pkg::ext_prod(prod_q));
    end
    if (op_i.st_mul2) begin
      prod_q <= gain_i * y_q;
    end
    // zero-length stage passes its input through
    if (op_i.st_wr && (s_len != '0)) begin
      v_q <= y_q;
    end
    if (op_i.fin_mul) begin
      prod_q <= sapd_pkg::GAIN_DRY * x_q;
    end
    if (op_i.fin_res) begin
      res_q <= sapd_pkg::rnd_sat(sapd_pkg::ext_prod(prod_q) + sapd_pkg::ext_q15(v_q));
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/stereo_tap_swell_allpass_diffuser_unit.sv =====
// channel   direction  signals
// in        input      in_valid_i / in_ready_o, left_in_i, right_in_i
// out       output     out_valid_o / out_ready_i, left_out_o, right_out_o
// cfg       input      cfg_we_i, diffuser_gain_i (write only)
//
// One item at a time: the taps take one read per cycle of the swell memory,
// and each diffuser stage runs a read, multiply, write sequence.
// After reset a clearing pass over max(SWELL_DEPTH, STAGE_COUNT*DIFFUSER_DEPTH)
// addresses (8192 at defaults) zeroes the memories; no input is taken meanwhile.
// A new input is taken while a result waits; a finished result holds until
// the output register frees.
module stereo_tap_swell_allpass_diffuser_unit #(
  parameter int SWELL_DEPTH    = sapd_pkg::SWELL_DEPTH_DEF,
  parameter int DIFFUSER_DEPTH = sapd_pkg::DIFFUSER_DEPTH_DEF,
  parameter int TAP_COUNT      = sapd_pkg::TAP_COUNT_DEF,
  parameter int STAGE_COUNT    = sapd_pkg::STAGE_COUNT_DEF,
  localparam int SW    = $clog2(SWELL_DEPTH),
  localparam int DN    = STAGE_COUNT * DIFFUSER_DEPTH,
  localparam int CLR_N = (SWELL_DEPTH > DN) ? SWELL_DEPTH : DN,
  localparam int CW    = $clog2(CLR_N)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sapd_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [sapd_pkg::SAMPLE_W-1:0] right_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sapd_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sapd_pkg::SAMPLE_W-1:0] right_out_o,
  input  logic                                 cfg_we_i,
  input  logic signed [sapd_pkg::COEF_W-1:0]   diffuser_gain_i
);

  sapd_pkg::sapd_op_t   op;
  sapd_pkg::sapd_stat_t stat;
  logic [SW-1:0]        wptr;
  logic                 clr_en;
  logic [CW-1:0]        clr_addr;
  logic                 out_free;
  logic signed [sapd_pkg::COEF_W-1:0]   gain_q, gain_c;
  logic signed [sapd_pkg::SAMPLE_W-1:0] left_res, right_res, left_q, right_q;
  logic                                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sapd_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= diffuser_gain_i;
    end
  end

  assign gain_c   = sapd_pkg::clamp_coef(gain_q);
  assign out_free = !out_valid_q || out_ready_i;

  sapd_ctrl #(
    .SWELL_DEPTH    (SWELL_DEPTH),
    .DIFFUSER_DEPTH (DIFFUSER_DEPTH),
    .TAP_COUNT      (TAP_COUNT),
    .STAGE_COUNT    (STAGE_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .op_o       (op),
    .stat_o     (stat),
    .wptr_o     (wptr),
    .clr_en_o   (clr_en),
    .clr_addr_o (clr_addr)
  );

  sapd_lane #(
    .CH             (0),
    .SWELL_DEPTH    (SWELL_DEPTH),
    .DIFFUSER_DEPTH (DIFFUSER_DEPTH),
    .STAGE_COUNT    (STAGE_COUNT)
  ) u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .wptr_i     (wptr),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .gain_i     (gain_c),
    .x_i        (left_in_i),
    .res_o      (left_res)
  );

  sapd_lane #(
    .CH             (1),
    .SWELL_DEPTH    (SWELL_DEPTH),
    .DIFFUSER_DEPTH (DIFFUSER_DEPTH),
    .STAGE_COUNT    (STAGE_COUNT)
  ) u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .wptr_i     (wptr),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .gain_i     (gain_c),
    .x_i        (right_in_i),
    .res_o      (right_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.out_load) begin
      left_q  <= left_res;
      right_q <= right_res;
    end
  end

  assign in_ready_o  = stat.in_ready;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !stat.out_load)
    else $error("result produced right after transfer");

endmodule
